// ===== rtl/harmonic_disk_force_accumulator_assert.svh =====
// Assertion macros used by the checker file of the force accumulator.
`ifndef HARMONIC_DISK_FORCE_ACCUMULATOR_ASSERT_SVH
`define HARMONIC_DISK_FORCE_ACCUMULATOR_ASSERT_SVH

// Property must hold at every rising clock edge outside reset.
`define HDFA_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
	else $error("hdfa assertion failed");

// Expression must never be true outside reset.
`define HDFA_ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(expr)) \
	else $error("hdfa forbidden condition seen");

`endif

// ===== rtl/hdfa_pkg.sv =====
`default_nettype none
package hdfa_pkg;

	localparam int NUM_PARTICLES = 1024;
	localparam int ADDR_W        = $clog2(NUM_PARTICLES);

	localparam int IDX_W   = 10;
	localparam int POS_W   = 22;
	localparam int DIAM_W  = 18;
	localparam int FORCE_W = 24;
	localparam int BOX_W   = 22;

	localparam logic [BOX_W-1:0] BOX_RESET = 22'd2473328;

	// Shared divider geometry
	localparam int DIV_DVD_W = 54;
	localparam int DIV_DVS_W = 38;
	localparam int DIV_Q_W   = 36;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_PAIR  = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_S,
		ST_CHECK,
		ST_SQRT,
		ST_DIVM_GO,
		ST_DIVM_WAIT,
		ST_MUL_FX,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_MUL_FY,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_RD_I,
		ST_UP_I,
		ST_RD_J,
		ST_UP_J,
		ST_READ
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_DVD_W-1:0] dividend;
		logic [DIV_DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/harmonic_disk_force_accumulator.sv =====
`default_nettype none
// Harmonic soft-disk force accumulator (2D, Q16 fixed point). Each input beat
// carries an operation in s_tuser: clear one force entry, accumulate one pair
// interaction into entries i (+F) and j (-F), or read one entry to m_tdata.
// After reset a clearing pass writes zero to all 1024 entries, one per cycle
// (s_tready low; configuration writes are still taken). A read waits out any
// output stall. A non-overlapping pair ends after the overlap test; an
// overlapping pair uses one shared multiplier, an 18-step bit-serial square
// root and three 36-step divisions through one shared divider, then a
// read-modify-write of both entries on the single memory port. Only one
// item is in work at a time; a read result waits in the output register
// while the next beat is taken. Sums saturate to 24 bits and set a sticky
// flag that only reset clears.
module harmonic_disk_force_accumulator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [21:0]  cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	// first_index, second_index, first_pos_x, first_pos_y, second_pos_x,
	// second_pos_y, first_diameter, second_diameter
	input  wire [143:0] s_tdata,
	// func
	input  wire [1:0]   s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// particle_index, force_x, force_y, saturated, zero pad
	output logic [63:0] m_tdata
);
	import hdfa_pkg::*;

	localparam int INIT_W = ADDR_W + 1;

	// Field views
	logic [IDX_W-1:0]  in_fi, in_si;
	logic [POS_W-1:0]  in_pxi, in_pyi, in_pxj, in_pyj;
	logic [DIAM_W-1:0] in_di, in_dj;

	assign in_fi  = s_tdata[9:0];
	assign in_si  = s_tdata[19:10];
	assign in_pxi = s_tdata[41:20];
	assign in_pyi = s_tdata[63:42];
	assign in_pxj = s_tdata[85:64];
	assign in_pyj = s_tdata[107:86];
	assign in_di  = s_tdata[125:108];
	assign in_dj  = s_tdata[143:126];

	function automatic logic signed [23:0] wrap_image(input logic signed [23:0] d,
			input logic [BOX_W-1:0] len);
		logic signed [24:0] d2;
		logic signed [24:0] ln;
		logic signed [24:0] r;
		d2 = {d, 1'b0};
		ln = $signed({3'b000, len});
		if (d2 >= ln) begin
			r = {d[23], d} - ln;
		end else if (d2 < -ln) begin
			r = {d[23], d} + ln;
		end else begin
			r = {d[23], d};
		end
		return r[23:0];
	endfunction

	// Returns {saturated, value}
	function automatic logic [FORCE_W:0] sat_add(input logic signed [FORCE_W-1:0] acc,
			input logic signed [37:0] delta);
		logic signed [38:0] s;
		s = 39'(acc) + 39'(delta);
		if (s > 39'sd8388607) begin
			return {1'b1, 24'h7FFFFF};
		end else if (s < -39'sd8388608) begin
			return {1'b1, 24'h800000};
		end
		return {1'b0, s[FORCE_W-1:0]};
	endfunction

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return 32'(idx) < NUM_PARTICLES;
	endfunction

	state_t state_q, state_d;

	logic [BOX_W-1:0]  box_q;
	logic              sat_q;
	logic [INIT_W-1:0] init_q;

	logic [IDX_W-1:0]         i_q, j_q;
	logic signed [23:0]       dx_q, dy_q;
	logic [18:0]              s_q;
	logic [47:0]              q_q;
	logic [37:0]              ss_q;
	logic [35:0]              sq_v_q;
	logic [36:0]              sq_res_q;
	logic [4:0]               sq_k_q;
	logic [33:0]              mag_q;
	logic [53:0]              prod_q;
	logic signed [36:0]       fx_q, fy_q;

	logic [23:0] adx, ady;
	logic [17:0] root;

	// Output register
	logic              out_load;
	logic [IDX_W-1:0]  out_idx_q;
	logic [23:0]       out_fx_q, out_fy_q;
	logic              out_sat_q;

	// Memory port
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [47:0]       mem_wdata, mem_rdata_q;
	logic [47:0]       mem [NUM_PARTICLES];

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign adx  = dx_q[23] ? 24'(-dx_q) : 24'(dx_q);
	assign ady  = dy_q[23] ? 24'(-dy_q) : 24'(dy_q);
	assign root = sq_res_q[17:0];

	// Shared multiplier
	logic [33:0] mul_a;
	logic [23:0] mul_b;
	logic [57:0] prod;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL_X:  begin mul_a = 34'(adx);  mul_b = adx;        end
			ST_MUL_Y:  begin mul_a = 34'(ady);  mul_b = ady;        end
			ST_MUL_S:  begin mul_a = 34'(s_q);  mul_b = 24'(s_q);   end
			ST_MUL_FX: begin mul_a = mag_q;     mul_b = adx;        end
			ST_MUL_FY: begin mul_a = mag_q;     mul_b = ady;        end
			default:   begin mul_a = '0;        mul_b = '0;         end
		endcase
		prod = 58'(mul_a) * 58'(mul_b);
	end

	// Square root step
	logic [36:0] sq_bit, sq_trial, sq_res_d;
	logic [35:0] sq_v_d;
	always_comb begin
		sq_bit   = 37'(1) << {sq_k_q, 1'b0};
		sq_trial = sq_res_q + sq_bit;
		if ({1'b0, sq_v_q} >= sq_trial) begin
			sq_v_d   = sq_v_q - sq_trial[35:0];
			sq_res_d = (sq_res_q >> 1) + sq_bit;
		end else begin
			sq_v_d   = sq_v_q;
			sq_res_d = sq_res_q >> 1;
		end
	end

	// Overlap test
	logic overlap;
	assign overlap = (q_q != '0) && ({q_q, 2'b00} < 50'(ss_q));

	// Saturating updates for the entry in the read data
	logic [37:0] fx_ext, fy_ext, delta_x, delta_y;
	logic [FORCE_W:0] sum_x, sum_y;
	always_comb begin
		fx_ext  = 38'(fx_q);
		fy_ext  = 38'(fy_q);
		delta_x = (state_q == ST_UP_J) ? -fx_ext : fx_ext;
		delta_y = (state_q == ST_UP_J) ? -fy_ext : fy_ext;
		sum_x   = sat_add(mem_rdata_q[47:24], delta_x);
		sum_y   = sat_add(mem_rdata_q[23:0], delta_y);
	end

	// Mean-diameter overlap term S - 2R; the dividend doubles it to 2*(S - 2R)
	logic [18:0] s_diff;
	assign s_diff = s_q - {root, 1'b0};

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		div_req   = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q[ADDR_W-1:0];
				if (init_q == INIT_W'(NUM_PARTICLES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(s_tuser))
						FUNC_CLEAR: begin
							mem_we    = in_range(in_fi);
							mem_waddr = ADDR_W'(in_fi);
						end
						FUNC_PAIR: state_d = ST_MUL_X;
						FUNC_READ: begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'(in_fi);
							state_d   = ST_READ;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL_X: state_d = ST_MUL_Y;
			ST_MUL_Y: state_d = ST_MUL_S;
			ST_MUL_S: state_d = ST_CHECK;
			ST_CHECK: state_d = overlap ? ST_SQRT : ST_IDLE;
			ST_SQRT: begin
				if (sq_k_q == '0) begin
					state_d = ST_DIVM_GO;
				end
			end
			ST_DIVM_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {2'b00, s_diff, 1'b0, 32'h0};
				div_req.divisor  = ss_q;
				state_d          = ST_DIVM_WAIT;
			end
			ST_DIVM_WAIT: if (div_rsp.done) state_d = ST_MUL_FX;
			ST_MUL_FX: state_d = ST_DIVX_GO;
			ST_DIVX_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = 38'(root);
				state_d          = ST_DIVX_WAIT;
			end
			ST_DIVX_WAIT: if (div_rsp.done) state_d = ST_MUL_FY;
			ST_MUL_FY: state_d = ST_DIVY_GO;
			ST_DIVY_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor  = 38'(root);
				state_d          = ST_DIVY_WAIT;
			end
			ST_DIVY_WAIT: if (div_rsp.done) state_d = ST_RD_I;
			ST_RD_I: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(i_q);
				state_d   = in_range(i_q) ? ST_UP_I : ST_RD_J;
			end
			ST_UP_I: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(i_q);
				mem_wdata = {sum_x[FORCE_W-1:0], sum_y[FORCE_W-1:0]};
				state_d   = ST_RD_J;
			end
			ST_RD_J: begin
				mem_re    = 1'b1;
				mem_raddr = ADDR_W'(j_q);
				state_d   = in_range(j_q) ? ST_UP_J : ST_IDLE;
			end
			ST_UP_J: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(j_q);
				mem_wdata = {sum_x[FORCE_W-1:0], sum_y[FORCE_W-1:0]};
				state_d   = ST_IDLE;
			end
			ST_READ: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q    <= BOX_RESET;
			sat_q    <= 1'b0;
			init_q   <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				box_q <= cfg_wdata;
			end
			if (state_q == ST_INIT) begin
				init_q <= init_q + INIT_W'(1);
			end
			if ((state_q == ST_UP_I) || (state_q == ST_UP_J)) begin
				sat_q <= sat_q | sum_x[FORCE_W] | sum_y[FORCE_W];
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Pair datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			i_q  <= in_fi;
			j_q  <= in_si;
			dx_q <= wrap_image($signed({2'b00, in_pxi}) - $signed({2'b00, in_pxj}), box_q);
			dy_q <= wrap_image($signed({2'b00, in_pyi}) - $signed({2'b00, in_pyj}), box_q);
			s_q  <= {1'b0, in_di} + {1'b0, in_dj};
		end
		case (state_q)
			ST_MUL_X: q_q  <= 48'(prod);
			ST_MUL_Y: q_q  <= q_q + 48'(prod);
			ST_MUL_S: ss_q <= 38'(prod);
			ST_CHECK: begin
				sq_v_q   <= q_q[35:0];
				sq_res_q <= '0;
				sq_k_q   <= 5'd17;
			end
			ST_SQRT: begin
				sq_v_q   <= sq_v_d;
				sq_res_q <= sq_res_d;
				sq_k_q   <= sq_k_q - 5'd1;
			end
			ST_DIVM_WAIT: if (div_rsp.done) mag_q <= div_rsp.quotient[33:0];
			ST_MUL_FX, ST_MUL_FY: prod_q <= 54'(prod);
			ST_DIVX_WAIT: begin
				if (div_rsp.done) begin
					fx_q <= dx_q[23] ? -$signed({1'b0, div_rsp.quotient})
						: $signed({1'b0, div_rsp.quotient});
				end
			end
			ST_DIVY_WAIT: begin
				if (div_rsp.done) begin
					fy_q <= dy_q[23] ? -$signed({1'b0, div_rsp.quotient})
						: $signed({1'b0, div_rsp.quotient});
				end
			end
			default: begin
			end
		endcase
	end

	// Force memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// Read result
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= i_q;
			out_fx_q  <= in_range(i_q) ? mem_rdata_q[47:24] : '0;
			out_fy_q  <= in_range(i_q) ? mem_rdata_q[23:0] : '0;
			out_sat_q <= sat_q;
		end
	end

	assign m_tdata = {5'b00000, out_sat_q, out_fy_q, out_fx_q, out_idx_q};

	hdfa_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/hdfa_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in DIV_Q_W bits.
module hdfa_divider (
	input  wire                 clk,
	input  wire                 arst_n,
	input  hdfa_pkg::div_req_t  req,
	output hdfa_pkg::div_rsp_t  rsp
);
	import hdfa_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_Q_W-1:0]   low_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVS_W-1:0] dvs_q;

	logic [DIV_DVS_W:0]   rem_sh;
	logic [DIV_DVS_W:0]   rem_sub;
	logic                 ge;

	// One trial subtraction
	always_comb begin
		rem_sh  = {rem_q, low_q[DIV_Q_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: dividend bits leave the top of low_q as quotient bits enter
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIV_DVS_W'(req.dividend >> DIV_Q_W);
			low_q <= req.dividend[DIV_Q_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIV_DVS_W-1:0] : rem_sh[DIV_DVS_W-1:0];
			low_q <= {low_q[DIV_Q_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = low_q;

endmodule
`default_nettype wire

// ===== rtl/hdfa_checker.sv =====
`default_nettype none
`include "harmonic_disk_force_accumulator_assert.svh"
// Port-level checks of the force accumulator.
module hdfa_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [63:0] m_tdata
);
	import hdfa_pkg::*;

	// Stalled result beat stays and holds its payload
	`HDFA_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	`HDFA_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata))

	// Pair and read keep the block busy for at least the next cycle
	`HDFA_ASSERT(a_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == FUNC_PAIR || s_tuser == FUNC_READ) |=> !s_tready)

	// Only a read creates a result; m_tvalid never rises in the cycle after any other beat
	`HDFA_ASSERT_NEVER(a_no_spurious, clk, arst_n, $rose(m_tvalid) && $past(s_tvalid && s_tready && s_tuser != FUNC_READ))

endmodule

bind harmonic_disk_force_accumulator hdfa_checker u_hdfa_checker (.*);
`default_nettype wire

// ===== dv/tb_harmonic_disk_force_accumulator.sv =====
`timescale 1ns / 1ps
module tb_harmonic_disk_force_accumulator;
	import hdfa_pkg::*;

	localparam int FMAX = 8388607;
	localparam int FMIN = -8388608;
	localparam int WATCHDOG_LIMIT = 20000;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [21:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;

	harmonic_disk_force_accumulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [9:0]  idx;
		logic [23:0] fx;
		logic [23:0] fy;
		logic        sat;
	} entry_read_t;

	// Shadow copy of the force memory
	int           shadow_fx [NUM_PARTICLES];
	int           shadow_fy [NUM_PARTICLES];
	bit           shadow_sat;
	longint       shadow_box;
	entry_read_t  pending_reads [$];
	int           fail_count;
	bit           src_idle_en;
	bit           sink_idle_en;
	int           quiet_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_add(int acc, longint delta);
		longint s;
		s = longint'(acc) + delta;
		if (s > FMAX) begin
			shadow_sat = 1'b1;
			return FMAX;
		end
		if (s < FMIN) begin
			shadow_sat = 1'b1;
			return FMIN;
		end
		return int'(s);
	endfunction

	function automatic longint nearest_image(longint d);
		if (2 * d >= shadow_box) return d - shadow_box;
		if (2 * d < -shadow_box) return d + shadow_box;
		return d;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	// Pair interaction: harmonic overlap force added to i, subtracted from j
	task automatic apply_pair(int i, int j, longint xi, longint yi, longint xj,
			longint yj, longint di, longint dj);
		longint dx, dy, s, r, fx, fy;
		longint unsigned q, mag, adx, ady;
		dx = nearest_image(xi - xj);
		dy = nearest_image(yi - yj);
		s = di + dj;
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		q = adx * adx + ady * ady;
		if (q == 0 || 4 * q >= s * s) return;
		r = root_floor(q);
		mag = ((2 * (s - 2 * r)) << 32) / (s * s);
		fx = longint'((mag * adx) / r);
		fy = longint'((mag * ady) / r);
		if (dx < 0) fx = -fx;
		if (dy < 0) fy = -fy;
		if (i < NUM_PARTICLES) begin
			shadow_fx[i] = clamp_add(shadow_fx[i], fx);
			shadow_fy[i] = clamp_add(shadow_fy[i], fy);
		end
		if (j < NUM_PARTICLES) begin
			shadow_fx[j] = clamp_add(shadow_fx[j], -fx);
			shadow_fy[j] = clamp_add(shadow_fy[j], -fy);
		end
	endtask

	task automatic predict(func_t f, int i, int j, logic [143:0] d);
		entry_read_t e;
		case (f)
			FUNC_CLEAR: begin
				shadow_fx[i] = 0;
				shadow_fy[i] = 0;
			end
			FUNC_PAIR: begin
				apply_pair(i, j, d[41:20], d[63:42], d[85:64], d[107:86],
					d[125:108], d[143:126]);
			end
			FUNC_READ: begin
				e.idx = i;
				e.fx  = shadow_fx[i][23:0];
				e.fy  = shadow_fy[i][23:0];
				e.sat = shadow_sat;
				pending_reads.push_back(e);
			end
			default: ;
		endcase
	endtask

	// Send one beat, with optional random idle burst first; valid stays high
	// after the beat so that beats can follow back to back
	task automatic send_beat(func_t f, int i, int j, int xi, int yi, int xj, int yj,
			int di, int dj);
		logic [143:0] d;
		d = {dj[17:0], di[17:0], yj[21:0], xj[21:0], yi[21:0], xi[21:0],
			j[9:0], i[9:0]};
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict(f, i, j, d);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		// a pair may still be in work after the last read returned
		repeat (200) @(posedge clk);
	endtask

	task automatic write_box(int len);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= len[21:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_box = len;
	endtask

	task automatic read_entry(int i);
		send_beat(FUNC_READ, i, 0, 0, 0, 0, 0, 0, 0);
	endtask

	// Random pair near a random spot, mostly overlapping, mid-range diameters mostly
	task automatic random_pair(int npart);
		int xi, yi, dx, dy, di, dj, span;
		di = $urandom_range(1, 3) == 1 ? $urandom_range(1, 262143)
			: $urandom_range(30000, 140000);
		dj = $urandom_range(30000, 140000);
		span = (di + dj) / 2;
		xi = $urandom_range(0, 4194303);
		yi = $urandom_range(0, 4194303);
		dx = $urandom_range(0, 2 * span) - span;
		dy = $urandom_range(0, 2 * span) - span;
		send_beat(FUNC_PAIR, $urandom_range(0, npart - 1), $urandom_range(0, npart - 1),
			xi, yi, (xi + dx) & 22'h3FFFFF, (yi + dy) & 22'h3FFFFF, di, dj);
	endtask

	task automatic test_directed();
		int k;
		write_box(2473328);
		read_entry(0);
		read_entry(1023);
		// zero distance
		send_beat(FUNC_PAIR, 1, 2, 100000, 100000, 100000, 100000, 65536, 65536);
		// no overlap
		send_beat(FUNC_PAIR, 1, 2, 0, 0, 1000000, 0, 65536, 65536);
		// overlap along x, then y
		send_beat(FUNC_PAIR, 1, 2, 70000, 5000, 20000, 5000, 65536, 65536);
		send_beat(FUNC_PAIR, 3, 4, 5000, 10000, 5000, 60000, 65536, 65536);
		// wrap across the box edge
		send_beat(FUNC_PAIR, 5, 6, 2473000, 2473000, 100, 100, 65536, 65536);
		// same index
		send_beat(FUNC_PAIR, 7, 7, 1000, 1000, 1100, 900, 262143, 262143);
		// extreme diameters, tiny distance, repeated on the same pair
		for (k = 0; k < 4; k++)
			send_beat(FUNC_PAIR, 8, 9, 0, 0, 1, 0, 262143, 262143);
		send_beat(FUNC_PAIR, 10, 11, 4194303, 4194303, 4194302, 4194303, 1, 1);
		for (k = 1; k < 12; k++) read_entry(k);
		send_beat(FUNC_CLEAR, 8, 0, 0, 0, 0, 0, 0, 0);
		read_entry(8);
		send_beat(FUNC_NONE, 1023, 1023, 4194303, 4194303, 4194303, 4194303,
			262143, 262143);
		read_entry(1023);
	endtask

	task automatic test_box_settings();
		write_box(65536);
		send_beat(FUNC_PAIR, 20, 21, 60000, 60000, 1000, 1000, 262143, 262143);
		read_entry(20);
		write_box(4194303);
		send_beat(FUNC_PAIR, 22, 23, 4194303, 0, 0, 4194303, 262143, 262143);
		send_beat(FUNC_PAIR, 22, 23, 4000000, 0, 10000, 0, 262143, 262143);
		read_entry(22);
		read_entry(23);
		write_box($urandom_range(65536, 4194303));
	endtask

	// Mostly pairs on the first npart entries, with clears, reads and random beats mixed in
	task automatic test_random(int count, int npart);
		int k, op;
		for (k = 0; k < count; k++) begin
			op = $urandom_range(0, 99);
			if (op < 55) random_pair(npart);
			else if (op < 85) read_entry($urandom_range(0, npart - 1));
			else if (op < 95) send_beat(FUNC_CLEAR, $urandom_range(0, npart - 1), 0,
				0, 0, 0, 0, 0, 0);
			else send_beat(func_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 4194303),
				$urandom_range(0, 4194303), $urandom_range(0, 4194303),
				$urandom_range(0, 4194303), $urandom_range(0, 262143),
				$urandom_range(0, 262143));
			if (k == count / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_reads.size() != 0);
			end
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		entry_read_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				$error("read beat with no read pending: %h", m_tdata);
				fail_count++;
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[9:0] !== want.idx) begin
					$error("particle_index exp %0d got %0d", want.idx, m_tdata[9:0]);
					fail_count++;
				end
				if (m_tdata[33:10] !== want.fx) begin
					$error("force_x exp %0d got %0d", $signed(want.fx),
						$signed(m_tdata[33:10]));
					fail_count++;
				end
				if (m_tdata[57:34] !== want.fy) begin
					$error("force_y exp %0d got %0d", $signed(want.fy),
						$signed(m_tdata[57:34]));
					fail_count++;
				end
				if (m_tdata[58] !== want.sat) begin
					$error("saturated exp %0b got %0b", want.sat, m_tdata[58]);
					fail_count++;
				end
			end
		end
	end

	// Output stall bursts
	initial begin
		m_tready = 1'b1;
		forever begin
			@(posedge clk);
			if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog; the post-reset clearing pass fits well inside the limit
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("harmonic_disk_force_accumulator regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = FUNC_NONE;
		fail_count   = 0;
		quiet_cycles = 0;
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		shadow_sat   = 1'b0;
		shadow_box   = BOX_RESET;
		for (int k = 0; k < NUM_PARTICLES; k++) begin
			shadow_fx[k] = 0;
			shadow_fy[k] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_box_settings();
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		test_random(500, 16);
		write_box(BOX_RESET);
		test_random(300, 1024);
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		test_random(200, 8);
		drain();
		if (fail_count == 0)
			$display("harmonic_disk_force_accumulator regression: pass");
		else
			$display("harmonic_disk_force_accumulator regression: fail");
		$finish;
	end

endmodule
